>>> hdl/triangle_circumcircle_assert.svh
// Assertion macros for the circumcircle port-level checker.
`ifndef TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH
`define TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcc same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcc next-cycle property violated");

`endif

>>> hdl/tcc_pkg.sv
// Widths, payload structs and helpers for the circumcircle pipeline.
`default_nettype none
package tcc_pkg;

   localparam int CW = 32;           // coordinate width
   localparam int EW = CW + 1;       // coordinate difference / sum
   localparam int PW = 2 * EW;       // product of two differences
   localparam int DW = PW + 1;       // determinant and bisector numerator
   localparam int LO = CW + 2;       // low split of DW for partial products
   localparam int HW = DW - LO;      // high split of DW
   localparam int NW = EW + DW + 1;  // centre numerators
   localparam int XW = NW + 1;       // dividend: |num| + |D|
   localparam int YW = DW + 1;       // divisor: 2|D|
   localparam int QW = EW;           // quotient bits kept
   localparam int SW = PW;           // squared distance
   localparam int TW = SW + 2;       // square root trial value
   localparam int RW = EW;           // root bits kept
   localparam int FS = 8;            // front stages
   localparam int IW = 6 * CW;       // request payload
   localparam int OW = 3 * CW;       // response payload

   typedef struct packed {
      logic [CW-1:0] ax;
      logic [CW-1:0] ay;
      logic          flat;
      logic          negx;
      logic          negy;
   } div_side_type;

   typedef struct packed {
      logic [CW-1:0] ox;
      logic [CW-1:0] oy;
      logic          flat;
      logic          ovf;
   } rad_side_type;

   typedef struct packed {
      logic [CW-1:0] ax;
      logic [CW-1:0] ay;
      rad_side_type  side;
   } rad_in_type;

   function automatic logic signed [EW-1:0] sext(input logic [CW-1:0] a);
      return $signed({a[CW-1], a});
   endfunction

endpackage
`default_nettype wire

>>> hdl/tcc_front.sv
// Front pipeline: determinant, numerators and divider operands.
`default_nettype none
module tcc_front import tcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [IW-1:0]        in_data,
   output logic                 out_valid,
   output logic [1:0][XW-1:0]   out_num,
   output logic [YW-1:0]        out_den,
   output div_side_type         out_side
);

   logic [FS-1:0] v_ff;

   logic [CW-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff, ax3_ff, ay3_ff, ax4_ff, ay4_ff;
   logic [CW-1:0] ax5_ff, ay5_ff, ax6_ff, ay6_ff, ax7_ff, ay7_ff;
   logic signed [EW-1:0] ux1_ff, uy1_ff, vx1_ff, vy1_ff, wx1_ff, wy1_ff, sx1_ff, sy1_ff;
   logic signed [EW-1:0] ux2_ff, uy2_ff, sx2_ff, sy2_ff;
   logic signed [EW-1:0] ux3_ff, uy3_ff, sx3_ff, sy3_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [DW-1:0] d3_ff, n3_ff, d4_ff, d5_ff, d6_ff;
   logic signed [LO:0]   dlo_in, nlo_in;
   logic signed [HW-1:0] dhi_in, nhi_in;
   logic signed [NW-1:0] pxl_ff, pxh_ff, pyl_ff, pyh_ff, qxl_ff, qxh_ff, qyl_ff, qyh_ff;
   logic signed [NW-1:0] sxd_ff, syd_ff, nuy_ff, nux_ff, numx_ff, numy_ff;
   logic [NW-1:0]        mx_ff, my_ff;
   logic [DW-1:0]        dm_ff;
   logic                 flat4_ff, flat5_ff, flat6_ff, flat7_ff;
   logic                 negx_ff, negy_ff;
   logic [1:0][XW-1:0]   num_ff;
   logic [YW-1:0]        den_ff;
   div_side_type         side_ff;

   assign dlo_in = $signed({1'b0, d3_ff[LO-1:0]});
   assign dhi_in = d3_ff[DW-1:LO];
   assign nlo_in = $signed({1'b0, n3_ff[LO-1:0]});
   assign nhi_in = n3_ff[DW-1:LO];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[FS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // side vectors and midpoint sums
         ax1_ff <= in_data[CW-1:0];
         ay1_ff <= in_data[2*CW-1:CW];
         ux1_ff <= sext(in_data[3*CW-1:2*CW]) - sext(in_data[CW-1:0]);
         uy1_ff <= sext(in_data[4*CW-1:3*CW]) - sext(in_data[2*CW-1:CW]);
         vx1_ff <= sext(in_data[5*CW-1:4*CW]) - sext(in_data[3*CW-1:2*CW]);
         vy1_ff <= sext(in_data[6*CW-1:5*CW]) - sext(in_data[4*CW-1:3*CW]);
         wx1_ff <= sext(in_data[CW-1:0]) - sext(in_data[5*CW-1:4*CW]);
         wy1_ff <= sext(in_data[2*CW-1:CW]) - sext(in_data[6*CW-1:5*CW]);
         sx1_ff <= sext(in_data[CW-1:0]) + sext(in_data[3*CW-1:2*CW]);
         sy1_ff <= sext(in_data[2*CW-1:CW]) + sext(in_data[4*CW-1:3*CW]);
         // cross and dot products
         p0_ff  <= uy1_ff * vx1_ff;
         p1_ff  <= ux1_ff * vy1_ff;
         p2_ff  <= wx1_ff * vx1_ff;
         p3_ff  <= wy1_ff * vy1_ff;
         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff;
         ux2_ff <= ux1_ff; uy2_ff <= uy1_ff; sx2_ff <= sx1_ff; sy2_ff <= sy1_ff;
         // determinant and numerator
         d3_ff  <= DW'(p0_ff) - DW'(p1_ff);
         n3_ff  <= DW'(p2_ff) + DW'(p3_ff);
         ax3_ff <= ax2_ff; ay3_ff <= ay2_ff;
         ux3_ff <= ux2_ff; uy3_ff <= uy2_ff; sx3_ff <= sx2_ff; sy3_ff <= sy2_ff;
         // split wide products
         pxl_ff <= sx3_ff * dlo_in;
         pxh_ff <= sx3_ff * dhi_in;
         pyl_ff <= sy3_ff * dlo_in;
         pyh_ff <= sy3_ff * dhi_in;
         qxl_ff <= nlo_in * uy3_ff;
         qxh_ff <= nhi_in * uy3_ff;
         qyl_ff <= nlo_in * ux3_ff;
         qyh_ff <= nhi_in * ux3_ff;
         d4_ff    <= d3_ff;
         flat4_ff <= (d3_ff == '0);
         ax4_ff <= ax3_ff; ay4_ff <= ay3_ff;
         // merge partial products
         sxd_ff <= (pxh_ff <<< LO) + pxl_ff;
         syd_ff <= (pyh_ff <<< LO) + pyl_ff;
         nuy_ff <= (qxh_ff <<< LO) + qxl_ff;
         nux_ff <= (qyh_ff <<< LO) + qyl_ff;
         d5_ff <= d4_ff; flat5_ff <= flat4_ff; ax5_ff <= ax4_ff; ay5_ff <= ay4_ff;
         // centre numerators
         numx_ff <= sxd_ff - nuy_ff;
         numy_ff <= syd_ff + nux_ff;
         d6_ff <= d5_ff; flat6_ff <= flat5_ff; ax6_ff <= ax5_ff; ay6_ff <= ay5_ff;
         // magnitudes and quotient signs
         mx_ff   <= numx_ff[NW-1] ? NW'(-numx_ff) : NW'(numx_ff);
         my_ff   <= numy_ff[NW-1] ? NW'(-numy_ff) : NW'(numy_ff);
         dm_ff   <= d6_ff[DW-1] ? DW'(-d6_ff) : DW'(d6_ff);
         negx_ff <= numx_ff[NW-1] ^ d6_ff[DW-1];
         negy_ff <= numy_ff[NW-1] ^ d6_ff[DW-1];
         flat7_ff <= flat6_ff; ax7_ff <= ax6_ff; ay7_ff <= ay6_ff;
         // rounding bias and divisor
         num_ff[0]     <= XW'(mx_ff) + XW'(dm_ff);
         num_ff[1]     <= XW'(my_ff) + XW'(dm_ff);
         den_ff        <= {dm_ff, 1'b0};
         side_ff.ax    <= ax7_ff;
         side_ff.ay    <= ay7_ff;
         side_ff.flat  <= flat7_ff;
         side_ff.negx  <= negx_ff;
         side_ff.negy  <= negy_ff;
      end
   end

   assign out_valid = v_ff[FS-1];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

>>> hdl/tcc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tcc_div import tcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [1:0][XW-1:0]   in_num,
   input  logic [YW-1:0]        in_den,
   input  div_side_type         in_side,
   output logic                 out_valid,
   output logic [1:0][QW-1:0]   out_quo,
   output logic [1:0]           out_ovf,
   output div_side_type         out_side
);

   logic                 vld_ff  [0:QW-1];
   logic [1:0][XW-1:0]   rem_ff  [0:QW-1];
   logic [1:0][QW-1:0]   quo_ff  [0:QW-1];
   logic [1:0]           ovf_ff  [0:QW-1];
   logic [YW-1:0]        den_ff  [0:QW-1];
   div_side_type         side_ff [0:QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int B = QW - 1 - s;
      logic               cur_vld;
      logic [1:0][XW-1:0] cur_rem;
      logic [1:0][QW-1:0] cur_quo;
      logic [1:0]         cur_ovf;
      logic [YW-1:0]      cur_den;
      div_side_type       cur_side;
      logic [XW-1:0]      trial;
      logic [1:0][XW-1:0] rem_in;
      logic [1:0][QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_rem  = in_num;
         assign cur_quo  = '0;
         assign cur_den  = in_den;
         assign cur_side = in_side;
         // quotient would not fit in QW bits
         assign cur_ovf[0] = in_num[0] >= (XW'(in_den) << QW);
         assign cur_ovf[1] = in_num[1] >= (XW'(in_den) << QW);
      end else begin : g_next
         assign cur_vld  = vld_ff[s-1];
         assign cur_rem  = rem_ff[s-1];
         assign cur_quo  = quo_ff[s-1];
         assign cur_ovf  = ovf_ff[s-1];
         assign cur_den  = den_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      assign trial = XW'(cur_den) << B;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (cur_rem[l] >= trial) begin
               rem_in[l] = cur_rem[l] - trial;
               quo_in[l] = cur_quo[l] | (QW'(1) << B);
            end else begin
               rem_in[l] = cur_rem[l];
               quo_in[l] = cur_quo[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            ovf_ff[s]  <= cur_ovf;
            den_ff[s]  <= cur_den;
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_ovf   = ovf_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
`default_nettype wire

>>> hdl/tcc_rad.sv
// Radius pipeline: squared distance, bitwise square root, rounding and clip.
`default_nettype none
module tcc_rad import tcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  rad_in_type    in_data,
   output logic          out_valid,
   output logic [CW-1:0] out_radius,
   output logic          out_ovf,
   output rad_side_type  out_side
);

   logic [2:0]           v_ff;
   logic signed [EW-1:0] dx_ff, dy_ff;
   logic signed [SW-1:0] sqx_in, sqy_in;
   logic [SW-1:0]        sqx_ff, sqy_ff, sum_ff;
   rad_side_type         s1_ff, s2_ff, s3_ff;

   logic                 vld_ff  [0:RW-1];
   logic [SW-1:0]        rem_ff  [0:RW-1];
   logic [RW-1:0]        root_ff [0:RW-1];
   rad_side_type         side_ff [0:RW-1];

   logic                 fin_vld_ff;
   logic [CW-1:0]        radius_ff;
   logic                 ovf_ff;
   rad_side_type         fin_side_ff;
   logic [RW-1:0]        round_in;

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= sext(in_data.side.ox) - sext(in_data.ax);
         dy_ff  <= sext(in_data.side.oy) - sext(in_data.ay);
         s1_ff  <= in_data.side;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         s2_ff  <= s1_ff;
         sum_ff <= sqx_ff + sqy_ff;
         s3_ff  <= s2_ff;
      end
   end

   for (genvar s = 0; s < RW; s++) begin : g_step
      localparam int B = RW - 1 - s;
      logic          cur_vld;
      logic [SW-1:0] cur_rem;
      logic [RW-1:0] cur_root;
      rad_side_type  cur_side;
      logic [TW-1:0] trial;
      logic [SW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (s == 0) begin : g_first
         assign cur_vld  = v_ff[2];
         assign cur_rem  = sum_ff;
         assign cur_root = '0;
         assign cur_side = s3_ff;
      end else begin : g_next
         assign cur_vld  = vld_ff[s-1];
         assign cur_rem  = rem_ff[s-1];
         assign cur_root = root_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      // (r + 2^B)^2 - r^2
      assign trial = (TW'(cur_root) << (B + 1)) | (TW'(1) << (2 * B));

      always_comb begin
         if (TW'(cur_rem) >= trial) begin
            rem_in  = SW'(TW'(cur_rem) - trial);
            root_in = cur_root | (RW'(1) << B);
         end else begin
            rem_in  = cur_rem;
            root_in = cur_root;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= cur_side;
         end
      end
   end

   // round to nearest: bump when s - r^2 exceeds r
   assign round_in = root_ff[RW-1] + RW'(rem_ff[RW-1] > SW'(root_ff[RW-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         fin_vld_ff <= vld_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         radius_ff   <= round_in[RW-1] ? '1 : round_in[CW-1:0];
         ovf_ff      <= round_in[RW-1];
         fin_side_ff <= side_ff[RW-1];
      end
   end

   assign out_valid  = fin_vld_ff;
   assign out_radius = radius_ff;
   assign out_ovf    = ovf_ff;
   assign out_side   = fin_side_ff;

endmodule
`default_nettype wire

>>> hdl/triangle_circumcircle.sv
// Top level of the circumscribed circle pipeline.
//
// Usage:
//   req_* carries one triangle per transfer: vertices A, B, C in signed
//   Q16.16. rsp_* returns one result per triangle, in order: centre,
//   radius (unsigned Q16.16) and two flags.
//   An accepted request passes through 8 front stages (products,
//   determinant, numerators), 33 divider stages (one quotient bit each),
//   1 saturation stage, 3 distance stages, 33 square root stages,
//   1 rounding stage and the output register before rsp_tvalid.
//   Throughput is one triangle per cycle while the receiver does not
//   stall; the depth of the divider and square root pipelines sets the
//   latency, the single shared enable sets the rate.
//   A flat triangle (zero determinant) returns zero centre and radius with
//   is_flat set and overflow clear.
//   Reset (synchronous, active high) drops every item in flight.
//   When the receiver stalls, the whole pipeline holds and req_tready falls;
//   nothing is lost or repeated, and bubbles stay where they are.
`default_nettype none
module triangle_circumcircle import tcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // first_x, first_y, second_x, second_y, third_x, third_y (32 bits each)
   input  logic [IW-1:0] req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // centre_x, centre_y, radius (32 bits each)
   output logic [OW-1:0] rsp_tdata,
   // is_flat, overflow
   output logic [1:0]    rsp_tuser
);

   logic               en;
   logic               fr_valid;
   logic [1:0][XW-1:0] fr_num;
   logic [YW-1:0]      fr_den;
   div_side_type       fr_side;
   logic               dv_valid;
   logic [1:0][QW-1:0] dv_quo;
   logic [1:0]         dv_ovf;
   div_side_type       dv_side;
   logic [1:0]         neg;
   logic [1:0][QW-1:0] limit;
   logic [1:0]         sat;
   logic [1:0][QW-1:0] mag;
   logic [1:0][QW-1:0] signed_q;
   logic               pv_ff;
   rad_in_type         post_ff;
   logic               rd_valid;
   logic [CW-1:0]      rd_radius;
   logic               rd_ovf;
   rad_side_type       rd_side;
   logic               rsp_tvalid_ff;
   logic [OW-1:0]      rsp_tdata_ff;
   logic [1:0]         rsp_tuser_ff;

   // advance everything when the output register is free or being taken
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   tcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (fr_valid),
      .out_num   (fr_num),
      .out_den   (fr_den),
      .out_side  (fr_side)
   );

   tcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf),
      .out_side  (dv_side)
   );

   // Saturate the rounded quotient to the signed range and apply the sign.
   assign neg = {dv_side.negy, dv_side.negx};

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         limit[l]    = (QW'(1) << (CW - 1)) - QW'(!neg[l]);
         sat[l]      = dv_ovf[l] || (dv_quo[l] > limit[l]);
         mag[l]      = sat[l] ? limit[l] : dv_quo[l];
         signed_q[l] = neg[l] ? (QW'(0) - mag[l]) : mag[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         post_ff.ax        <= dv_side.ax;
         post_ff.ay        <= dv_side.ay;
         post_ff.side.ox   <= signed_q[0][CW-1:0];
         post_ff.side.oy   <= signed_q[1][CW-1:0];
         post_ff.side.flat <= dv_side.flat;
         post_ff.side.ovf  <= |sat;
      end
   end

   tcc_rad u_rad (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (pv_ff),
      .in_data    (post_ff),
      .out_valid  (rd_valid),
      .out_radius (rd_radius),
      .out_ovf    (rd_ovf),
      .out_side   (rd_side)
   );

   // Output register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (rd_side.flat) begin
            // drop the meaningless quotient of a flat triangle
            rsp_tdata_ff <= '0;
            rsp_tuser_ff <= 2'b01;
         end else begin
            rsp_tdata_ff <= {rd_radius, rd_side.oy, rd_side.ox};
            rsp_tuser_ff <= {rd_side.ovf || rd_ovf, 1'b0};
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

>>> hdl/tcc_chk.sv
// Port-level checker for the circumcircle block, bound to the top level.
`default_nettype none
`include "triangle_circumcircle_assert.svh"
module tcc_chk import tcc_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic [IW-1:0] req_tdata,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [OW-1:0] rsp_tdata,
   input logic [1:0]    rsp_tuser
);

   // stalled result holds
   `TCC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // the input side moves exactly when the output register can move
   `TCC_ASSERT_NOW(a_ready, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   // flat triangles carry zero centre and radius and no overflow
   `TCC_ASSERT_NOW(a_flat, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])
   // reset empties the pipeline
   `TCC_ASSERT_NEXT(a_reset, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind triangle_circumcircle tcc_chk u_chk (.*);
`default_nettype wire

>>> sim/tcc_checker.sv
// Checker for the circumcircle block: predicts each result and compares it.
`default_nettype none
module tcc_checker import tcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [IW-1:0] req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [OW-1:0] rsp_tdata,
   input  logic [1:0]    rsp_tuser,
   output int            mismatches,
   output int            pending,
   output int            results_seen,
   output int            flats_seen,
   output int            ovfs_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CW-1:0] cx;
      logic [CW-1:0] cy;
      logic [CW-1:0] rad;
      logic          flat;
      logic          ovf;
   } circle_type;

   circle_type circles_due[$];

   // Round-to-nearest quotient (ties away from zero), clipped to the signed range.
   function automatic logic signed [CW-1:0] round_clip(input logic signed [199:0] num,
                                                       input logic signed [199:0] den,
                                                       inout logic ovf);
      logic [199:0] mn, md, q;
      logic          neg;
      logic [199:0] lim;
      mn  = num < 0 ? -num : num;
      md  = den < 0 ? -den : den;
      neg = (num < 0) ^ (den < 0);
      q   = (2 * mn + md) / (2 * md);
      lim = neg ? 200'h8000_0000 : 200'h7fff_ffff;
      if (q > lim) begin
         ovf = 1'b1;
         q   = lim;
      end
      return neg ? -q[CW-1:0] : q[CW-1:0];
   endfunction

   function automatic circle_type circumcircle(input logic [IW-1:0] points);
      logic signed [199:0] ax, ay, bx, by, cx, cy, ux, uy, vx, vy, wx, wy;
      logic signed [199:0] det, nsum, numx, numy, ox, oy, dx, dy;
      logic [199:0]        sq, r;
      circle_type          res;
      ax = $signed(points[0*CW +: CW]);
      ay = $signed(points[1*CW +: CW]);
      bx = $signed(points[2*CW +: CW]);
      by = $signed(points[3*CW +: CW]);
      cx = $signed(points[4*CW +: CW]);
      cy = $signed(points[5*CW +: CW]);
      ux = bx - ax; uy = by - ay; vx = cx - bx; vy = cy - by;
      wx = ax - cx; wy = ay - cy;
      det = uy * vx - ux * vy;
      res = '0;
      if (det == 0) begin
         res.flat = 1'b1;
         return res;
      end
      nsum = wx * vx + wy * vy;
      numx = (ax + bx) * det - nsum * uy;
      numy = (ay + by) * det + nsum * ux;
      res.cx = round_clip(numx, 2 * det, res.ovf);
      res.cy = round_clip(numy, 2 * det, res.ovf);
      ox = $signed(res.cx);
      oy = $signed(res.cy);
      dx = ox - ax;
      dy = oy - ay;
      sq = dx * dx + dy * dy;
      r  = '0;
      for (int b = 55; b >= 0; b--) begin
         if ((r | (200'd1 << b)) * (r | (200'd1 << b)) <= sq) r = r | (200'd1 << b);
      end
      if (sq > r * (r + 1)) r = r + 1;
      if (r > 200'hffff_ffff) begin
         res.ovf = 1'b1;
         r       = 200'hffff_ffff;
      end
      res.rad = r[CW-1:0];
      return res;
   endfunction

   assign pending = circles_due.size();

   always @(posedge clock) begin
      circle_type want, got;
      if (reset) begin
         circles_due.delete();
         mismatches   <= 0;
         results_seen <= 0;
         flats_seen   <= 0;
         ovfs_seen    <= 0;
      end else begin
         if (req_tvalid && req_tready) circles_due.push_back(circumcircle(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0 +: CW], rsp_tdata[CW +: CW], rsp_tdata[2*CW +: CW],
                   rsp_tuser[0], rsp_tuser[1]};
            results_seen <= results_seen + 1;
            flats_seen   <= flats_seen + got.flat;
            ovfs_seen    <= ovfs_seen + got.ovf;
            if (circles_due.size() == 0) begin
               if (mismatches < 10) $display("unexpected result %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = circles_due.pop_front();
               if (want !== got) begin
                  if (mismatches < 10)
                     $display("result mismatch: cx %h/%h cy %h/%h r %h/%h flat %b/%b ovf %b/%b",
                              want.cx, got.cx, want.cy, got.cy, want.rad, got.rad,
                              want.flat, got.flat, want.ovf, got.ovf);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench top for the circumcircle block: stimulus, stall patterns and verdict.
`default_nettype none
module tb;
   import tcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 80;
   localparam int WATCHDOG    = 20000;
   localparam int HOLD_CYCLES = 400;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [IW-1:0] req_tdata;   // first_x, first_y, second_x, second_y, third_x, third_y
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [OW-1:0] rsp_tdata;   // centre_x, centre_y, radius
   logic [1:0]    rsp_tuser;   // is_flat, overflow
   int            mismatches, pending, results_seen, flats_seen, ovfs_seen;
   int            send_idle_pct, recv_idle_pct;
   bit            hold_start;   // stimulus asks the receiver for one long hold-off
   bit            hold_taken;
   int            hold_off;     // cycles the receiver keeps rsp_tready low
   int            idle_cycles;
   int            sent;

   triangle_circumcircle u_dut (.*);

   tcc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_off   <= 0;
         hold_taken <= 1'b0;
      end else if (hold_start && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_off   <= HOLD_CYCLES - 1;
         hold_taken <= 1'b1;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off   <= hold_off - 1;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 255) - 128;
         3, 4: return {{16{1'b0}}, 16'($urandom)} - 32'h8000 + (32'($urandom_range(255)) << 16);
         default: return $urandom;
      endcase
   endfunction

   // Offer one triangle and hold it until the transfer completes.
   task automatic send_tri(input logic [IW-1:0] points);
      while (($urandom_range(99) < send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= points;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic send_random(input int count);
      logic [CW-1:0] p [6];
      for (int i = 0; i < count; i++) begin
         foreach (p[k]) p[k] = pick_coord();
         case ($urandom_range(9))
            0: begin p[2] = p[0]; p[3] = p[1]; end            // coincident points
            1: begin p[4] = 2*p[2] - p[0]; p[5] = 2*p[3] - p[1]; end  // collinear
            2: begin p[3] = p[1]; p[5] = p[1]; end            // horizontal line
            default: ;
         endcase
         send_tri({p[5], p[4], p[3], p[2], p[1], p[0]});
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [CW-1:0] q1, m1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      hold_start = 1'b0;
      sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, flat cases and simple right triangles.
      q1 = 32'h0001_0000;
      m1 = 32'hffff_0000;
      send_tri('0);                                                   // all points coincide
      send_tri({q1, q1, q1, q1, 32'h0, 32'h0});                       // two coincide
      send_tri({32'h2_0000, 32'h2_0000, q1, q1, 32'h0, 32'h0});       // collinear
      send_tri({q1, 32'h0, 32'h0, q1, 32'h0, 32'h0});                 // right triangle
      send_tri({32'h0, m1, m1, 32'h0, q1, q1});
      send_tri({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff});                       // huge coordinates
      send_tri({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000});
      send_tri({32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff});
      send_tri({32'h0, 32'h3, 32'h1, 32'h0, 32'h0, 32'h0});           // tiny, rounding
      send_tri({32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0});
      send_tri({32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000, 32'h7fff_fffe,
                32'h0, 32'h0});                                       // nearly flat
      send_tri({32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0});
      send_tri({32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                32'hffff_ffff, 32'h0});
      drain();

      // Long receiver hold-off while the sender keeps offering.
      hold_start <= 1'b1;
      send_random(150);
      drain();

      send_idle_pct = 14; recv_idle_pct = 70;
      send_random(600);
      drain();
      send_idle_pct = 70; recv_idle_pct = 14;
      send_random(600);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      send_random(550);
      drain();
      repeat (LATENCY + 20) @(posedge clock);

      $display("Covered %0d triangles: %0d results, %0d flat, %0d saturated.",
               sent, results_seen, flats_seen, ovfs_seen);
      if (mismatches == 0 && pending == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_div.sv
hdl/tcc_rad.sv
hdl/triangle_circumcircle.sv
hdl/tcc_chk.sv
sim/tcc_checker.sv
sim/tb.sv
